[rtl/block_bitmap_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shared property forms for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Sizes, request and status codes, and the control/status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int BLOCK_COUNT  = 8192;
   localparam int WORD_BITS    = 32;
   localparam int BIT_AW       = $clog2(WORD_BITS);
   localparam int BITMAP_WORDS = (BLOCK_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW      = $clog2(BITMAP_WORDS);
   localparam int INDEX_W      = 13;
   localparam int RESV_W       = 14;
   localparam int DATA_W       = 16;
   localparam int TAIL_BITS    = BLOCK_COUNT % WORD_BITS;

   localparam logic [RESV_W-1:0]    RESERVED_RESET = RESV_W'(256);
   localparam logic [WORD_AW-1:0]   LAST_WORD      = WORD_AW'(BITMAP_WORDS - 1);
   // Bits of the last word that stand for real blocks.
   localparam logic [WORD_BITS-1:0] TAIL_MASK =
      (TAIL_BITS == 0) ? {WORD_BITS{1'b1}} : WORD_BITS'((64'd1 << TAIL_BITS) - 64'd1);

   // Request kinds; any other code is served as a query.
   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_MARK  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // Which result the datapath loads into the output register.
   localparam logic [1:0] FIN_ACCESS = 2'd0;
   localparam logic [1:0] FIN_ALLOC  = 2'd1;
   localparam logic [1:0] FIN_FULL   = 2'd2;
   localparam logic [1:0] FIN_RANGE  = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       rd_issue;
      logic       scan;
      logic       finish_en;
      logic [1:0] fin;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic alloc_none;
      logic idx_range;
      logic hit;
      logic last;
   } dp_status_type;

endpackage

[rtl/block_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit allocator over a used/free bitmap of 8192 blocks, with mark and
// query access to single bits.
//
//   Group   Dir  Handshake             Carries
//   req_    in   req_tvalid/tready     tuser: kind; tdata: block index, mark
//   rsp_    out  rsp_tvalid/tready     tuser: status; tdata: block, bit
//   csr_    in   csr_wr_en             reserved block count
//
// Mark and query pass through decode, a word read and the access step before
// the result enters the output register. Allocate reads one bitmap word at a
// time, the scan starting at the word of the reserved limit, as the bitmap
// memory has one read port.
// One request is in work at a time; a new one is taken while the last result
// waits in the output register, and a stalled output holds the next finish.
// Reset clears the per-word valid bits at once, so the bitmap reads as all
// free right after reset with no clearing pass.
// ----------------------------------------------------------------------------
module block_bitmap_allocator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bba_pkg::DATA_W-1:0] req_tdata,  // [12:0] block_index, [13] mark_value
   input  logic [1:0]                 req_tuser,  // [1:0] req_type
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bba_pkg::DATA_W-1:0] rsp_tdata,  // [12:0] result_block, [13] bit_value
   output logic [1:0]                 rsp_tuser,  // [1:0] status
   input  logic                       csr_wr_en,
   input  logic [bba_pkg::RESV_W-1:0] csr_wr_data
);

   bba_pkg::ctrl_cmd_type  cmd;
   bba_pkg::dp_status_type sts;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bba_datapath.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator datapath
// Request capture, bitmap memory with per-word valid bits, free-bit search
// over one word, read-modify-write and the result register.
// ----------------------------------------------------------------------------
module bba_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bba_pkg::DATA_W-1:0]  req_tdata,
   input  logic [1:0]                  req_tuser,
   input  logic                        csr_wr_en,
   input  logic [bba_pkg::RESV_W-1:0]  csr_wr_data,
   input  bba_pkg::ctrl_cmd_type       cmd,
   output bba_pkg::dp_status_type      sts,
   output logic [bba_pkg::DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                  rsp_tuser
);

   localparam int WA = bba_pkg::WORD_AW;
   localparam int WB = bba_pkg::WORD_BITS;

   logic [bba_pkg::RESV_W-1:0]  reserved_ff;
   logic [1:0]                  kind_ff;
   logic [bba_pkg::INDEX_W-1:0] idx_ff;
   logic                        mark_ff;
   logic [WA-1:0]               scan_addr_ff;
   logic [WA-1:0]               chk_addr_ff;
   logic                        rd_valid_ff;
   logic [bba_pkg::BITMAP_WORDS-1:0] word_valid_ff;

   logic [bba_pkg::INDEX_W-1:0] res_block_ff;
   logic                        res_bit_ff;
   logic [1:0]                  res_status_ff;

   logic [WA-1:0]               start_word;
   logic [WA-1:0]               idx_word;
   logic [bba_pkg::BIT_AW-1:0]  idx_bit;
   logic [WA-1:0]               rd_addr;
   logic [WB-1:0]               ram_q;
   logic [WB-1:0]               word;
   logic [WB-1:0]               low_mask;
   logic [WB-1:0]               free_vec;
   logic [WB-1:0]               low_onehot;
   logic [bba_pkg::BIT_AW-1:0]  free_pos;
   logic [WB-1:0]               bit_sel;
   logic [WB-1:0]               mark_word;
   logic                        wr_en;
   logic [WA-1:0]               wr_addr;
   logic [WB-1:0]               wr_data;

   assign start_word = WA'(reserved_ff >> bba_pkg::BIT_AW);
   assign idx_word   = WA'(idx_ff >> bba_pkg::BIT_AW);
   assign idx_bit    = idx_ff[bba_pkg::BIT_AW-1:0];
   assign rd_addr    = cmd.scan ? scan_addr_ff : idx_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= bba_pkg::RESERVED_RESET;
      end else if (csr_wr_en) begin
         reserved_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff      <= req_tuser;
         idx_ff       <= req_tdata[bba_pkg::INDEX_W-1:0];
         mark_ff      <= req_tdata[bba_pkg::INDEX_W];
         scan_addr_ff <= start_word;
      end else if (cmd.rd_issue && cmd.scan) begin
         scan_addr_ff <= scan_addr_ff + WA'(1);
      end
      if (cmd.rd_issue) begin
         chk_addr_ff <= rd_addr;
         rd_valid_ff <= word_valid_ff[rd_addr];
      end
   end

   // A word that was never written reads as all free.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
      end else if (wr_en) begin
         word_valid_ff[wr_addr] <= 1'b1;
      end
   end

   bba_ram #(
      .WIDTH(WB),
      .DEPTH(bba_pkg::BITMAP_WORDS)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_issue),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   assign word = rd_valid_ff ? ram_q : '0;

   // Blocks below the reserved limit count as used in the first scanned word,
   // and bits past the block count as used in the last one.
   always_comb begin
      low_mask = '0;
      if (chk_addr_ff == start_word) begin
         low_mask = (WB'(1) << reserved_ff[bba_pkg::BIT_AW-1:0]) - WB'(1);
      end
      free_vec = ~word & ~low_mask;
      if (chk_addr_ff == bba_pkg::LAST_WORD) begin
         free_vec = free_vec & bba_pkg::TAIL_MASK;
      end
   end

   assign low_onehot = free_vec & (~free_vec + WB'(1));

   always_comb begin
      free_pos = '0;
      for (int j = 0; j < WB; j++) begin
         if (low_onehot[j]) begin
            free_pos = free_pos | bba_pkg::BIT_AW'(j);
         end
      end
   end

   assign bit_sel   = WB'(1) << idx_bit;
   assign mark_word = mark_ff ? (word | bit_sel) : (word & ~bit_sel);

   assign wr_en = cmd.finish_en &&
                  ((cmd.fin == bba_pkg::FIN_ACCESS && kind_ff == bba_pkg::REQ_MARK) ||
                   cmd.fin == bba_pkg::FIN_ALLOC);
   assign wr_addr = (cmd.fin == bba_pkg::FIN_ALLOC) ? chk_addr_ff : idx_word;
   assign wr_data = (cmd.fin == bba_pkg::FIN_ALLOC) ? (word | low_onehot) : mark_word;

   always_ff @(posedge clock) begin
      if (cmd.finish_en) begin
         case (cmd.fin)
            bba_pkg::FIN_ACCESS: begin
               res_block_ff  <= idx_ff;
               res_bit_ff    <= (kind_ff == bba_pkg::REQ_MARK) ? mark_ff : word[idx_bit];
               res_status_ff <= bba_pkg::ST_OK;
            end
            bba_pkg::FIN_ALLOC: begin
               res_block_ff  <= bba_pkg::INDEX_W'({chk_addr_ff, free_pos});
               res_bit_ff    <= 1'b1;
               res_status_ff <= bba_pkg::ST_OK;
            end
            bba_pkg::FIN_FULL: begin
               res_block_ff  <= '0;
               res_bit_ff    <= 1'b0;
               res_status_ff <= bba_pkg::ST_FULL;
            end
            default: begin
               res_block_ff  <= idx_ff;
               res_bit_ff    <= 1'b0;
               res_status_ff <= bba_pkg::ST_RANGE;
            end
         endcase
      end
   end

   assign sts.is_alloc   = (kind_ff == bba_pkg::REQ_ALLOC);
   assign sts.alloc_none = (32'(reserved_ff) >= 32'(bba_pkg::BLOCK_COUNT));
   assign sts.idx_range  = (32'(idx_ff) >= 32'(bba_pkg::BLOCK_COUNT));
   assign sts.hit        = |free_vec;
   assign sts.last       = (chk_addr_ff == bba_pkg::LAST_WORD);

   assign rsp_tdata = bba_pkg::DATA_W'({res_bit_ff, res_block_ff});
   assign rsp_tuser = res_status_ff;

endmodule

[rtl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// Block bitmap allocator controller
// Sequences one request at a time: decode, word reads, the scan loop and the
// hand-off into the output register.
// ----------------------------------------------------------------------------
`include "block_bitmap_allocator_assert.svh"

module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  bba_pkg::dp_status_type sts,
   output bba_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_ACCESS = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_DIRECT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.rd_issue  = 1'b0;
      cmd.scan      = 1'b0;
      cmd.finish_en = 1'b0;
      cmd.fin       = bba_pkg::FIN_ACCESS;
      req_tready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_alloc) begin
               if (sts.alloc_none) begin
                  state_in = S_DIRECT;
               end else begin
                  cmd.rd_issue = 1'b1;
                  cmd.scan     = 1'b1;
                  state_in     = S_SCAN;
               end
            end else if (sts.idx_range) begin
               state_in = S_DIRECT;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_ACCESS;
            end
         end
         S_ACCESS: begin
            cmd.fin = bba_pkg::FIN_ACCESS;
            if (out_free) begin
               cmd.finish_en = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            cmd.fin  = sts.hit ? bba_pkg::FIN_ALLOC : bba_pkg::FIN_FULL;
            if (sts.hit || sts.last) begin
               if (out_free) begin
                  cmd.finish_en = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               // Keep one word read in flight per cycle until a free bit turns up or the last word is read.
               cmd.rd_issue = 1'b1;
            end
         end
         S_DIRECT: begin
            cmd.fin = sts.is_alloc ? bba_pkg::FIN_FULL : bba_pkg::FIN_RANGE;
            if (out_free) begin
               cmd.finish_en = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish_en || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `BBA_ASSERT_SAME(a_finish_room, clock, reset, cmd.finish_en, !rsp_valid_ff || rsp_tready, "result loaded over an unread word")
   `BBA_ASSERT_SAME(a_alloc_hit, clock, reset, cmd.finish_en && cmd.fin == bba_pkg::FIN_ALLOC, sts.hit, "allocation without a free bit")
   `BBA_ASSERT_SAME(a_scan_read, clock, reset, cmd.rd_issue && state_ff == S_SCAN, !sts.hit && !sts.last, "scan read past its end")
   `BBA_ASSERT_NEXT(a_result_out, clock, reset, cmd.finish_en, rsp_valid_ff && state_ff == S_IDLE, "finished request not offered")

endmodule
